// ----- rtl/dcss_pkg.sv -----
package dcss_pkg;

  localparam int unsigned IdW   = 11;
  localparam int unsigned LenW  = 4;
  localparam int unsigned ValW  = 15;
  localparam int unsigned ModeW = 2;
  localparam int unsigned AddrW = 2;

  localparam logic [ModeW-1:0] MODE_AUTO   = 2'd0;
  localparam logic [ModeW-1:0] MODE_MANUAL = 2'd1;
  localparam logic [ModeW-1:0] MODE_DEBUG  = 2'd2;

  localparam logic [AddrW-1:0] REG_ID_MODE  = 2'd0;
  localparam logic [AddrW-1:0] REG_ID_STEER = 2'd1;
  localparam logic [AddrW-1:0] REG_ID_ESTOP = 2'd2;
  localparam logic [AddrW-1:0] REG_ID_MOTOR = 2'd3;

  localparam logic [0:0] OP_FRAME = 1'b0;

  localparam logic signed [ValW-1:0] UNIT_ONE       = 15'sd10000;
  localparam logic signed [ValW-1:0] CREEP_THROTTLE = 15'sd700;
  localparam logic signed [ValW-1:0] RAW_SCALE      = 15'sd100;

  localparam logic [ValW-1:0] DEADBAND    = 15'd300;
  localparam logic [ValW-1:0] CLOSE_BAND  = 15'd200;
  localparam logic [ValW-1:0] DIRECT_TURN = 15'd2000;
  localparam logic [ValW-1:0] LARGE_STEP  = 15'd2500;
  localparam logic [ValW-1:0] MEDIUM_BAND = 15'd1000;

  // ceil(2^16 * 65 / 100), exact floor for step sizes up to LARGE_STEP
  localparam logic [15:0] MAJOR_RECIP = 16'd42599;

  typedef struct packed {
    logic [IdW-1:0] id_mode;
    logic [IdW-1:0] id_steer;
    logic [IdW-1:0] id_estop;
    logic [IdW-1:0] id_motor;
  } ids_t;

  typedef struct packed {
    logic            operation;
    logic [IdW-1:0]  frame_id;
    logic [LenW-1:0] frame_len;
    logic [7:0]      byte_low;
    logic [7:0]      byte_high;
    logic            time_elapsed;
  } item_t;

  typedef struct packed {
    logic signed [ValW-1:0] steer_out;
    logic signed [ValW-1:0] throttle_goal;
    logic                   brake_on;
    logic [ModeW-1:0]       drive_mode;
    logic                   pid_clear;
    logic                   control_ran;
  } result_t;

endpackage

// ----- rtl/dcss_smooth.sv -----
module dcss_smooth (
  input  logic signed [dcss_pkg::ValW-1:0] goal,
  input  logic signed [dcss_pkg::ValW-1:0] pos,
  output logic signed [dcss_pkg::ValW-1:0] pos_next
);
  import dcss_pkg::*;

  logic [ValW-1:0]        abs_g;
  logic [ValW-1:0]        abs_t;
  logic signed [ValW-1:0] t;
  logic signed [ValW:0]   d;
  logic [ValW:0]          d_neg;
  logic [ValW-1:0]        ad;
  logic [11:0]            ad12;
  logic [27:0]            prod;
  logic [11:0]            q;
  logic signed [ValW:0]   sum;

  always_comb begin
    abs_g = goal[ValW-1] ? ValW'(-goal) : ValW'(goal);
    if (abs_g < DEADBAND) begin
      t     = '0;
      abs_t = '0;
    end else begin
      t     = goal;
      abs_t = abs_g;
    end
    d     = (ValW+1)'(t) - (ValW+1)'(pos);
    d_neg = -d;
    ad    = d[ValW] ? d_neg[ValW-1:0] : d[ValW-1:0];
    ad12  = ad[11:0];
    prod  = 28'(ad12) * 28'(MAJOR_RECIP);
    q     = (abs_t > MEDIUM_BAND) ? prod[27:16] : (ad12 >> 2);
    sum   = d[ValW] ? ((ValW+1)'(pos) - (ValW+1)'(q)) : ((ValW+1)'(pos) + (ValW+1)'(q));

    if (ad < CLOSE_BAND) begin
      pos_next = t;
    end else if (abs_t > DIRECT_TURN || ad > LARGE_STEP) begin
      pos_next = t;
    end else if (sum > (ValW+1)'(UNIT_ONE)) begin
      pos_next = UNIT_ONE;
    end else if (sum < -(ValW+1)'(UNIT_ONE)) begin
      pos_next = -UNIT_ONE;
    end else begin
      pos_next = sum[ValW-1:0];
    end
  end

endmodule

// ----- rtl/dcss_core.sv -----
module dcss_core (
  input  logic              clk,
  input  logic              rst,
  input  dcss_pkg::ids_t    ids,
  input  logic              go,
  input  dcss_pkg::item_t   item,
  output dcss_pkg::result_t res
);
  import dcss_pkg::*;

  logic [ModeW-1:0]       mode_reg, mode_reg_next;
  logic signed [ValW-1:0] steer_goal, steer_goal_next;
  logic signed [ValW-1:0] steer_position, steer_position_next;
  logic signed [ValW-1:0] throttle_reg, throttle_reg_next;
  logic                   brake_reg, brake_reg_next;

  logic [15:0]            u16;
  logic signed [15:0]     raw;
  logic                   short_len;
  logic signed [7:0]      rc;
  logic signed [ValW-1:0] rcx;
  logic signed [ValW-1:0] long_val;
  logic signed [ValW-1:0] sat_val;
  logic                   estop_on, estop_off;
  logic                   consumed, pid_clear, ran;
  logic signed [ValW-1:0] smooth_pos;

  dcss_smooth u_smooth (
    .goal     (steer_goal),
    .pos      (steer_position),
    .pos_next (smooth_pos)
  );

  always_comb begin
    u16       = {item.byte_high, item.byte_low};
    raw       = $signed(u16);
    short_len = item.frame_len < LenW'(2);
    if (raw > 16'sd100) begin
      rc = 8'sd100;
    end else if (raw < -16'sd100) begin
      rc = -8'sd100;
    end else begin
      rc = raw[7:0];
    end
    rcx      = ValW'(rc);
    long_val = rcx * RAW_SCALE;
    if (short_len) begin
      sat_val   = (item.byte_low == 8'd0) ? '0 : UNIT_ONE;
      estop_on  = item.byte_low == 8'd1 || item.byte_low == 8'd5;
      estop_off = item.byte_low == 8'd0;
    end else begin
      sat_val   = long_val;
      estop_on  = raw >= 16'sd100;
      estop_off = raw == 16'sd0;
    end

    mode_reg_next       = mode_reg;
    steer_goal_next     = steer_goal;
    steer_position_next = steer_position;
    throttle_reg_next   = throttle_reg;
    brake_reg_next      = brake_reg;
    consumed            = 1'b0;
    pid_clear           = 1'b0;
    ran                 = 1'b0;

    if (item.operation == OP_FRAME) begin
      if (item.frame_id == ids.id_mode) begin
        consumed = 1'b1;
        if (u16 <= 16'd2) begin
          mode_reg_next       = u16[ModeW-1:0];
          pid_clear           = 1'b1;
          steer_position_next = steer_goal;
          if (u16 != 16'd0) begin
            throttle_reg_next = '0;
            steer_goal_next   = '0;
          end
        end
      end else if (item.frame_id == ids.id_steer) begin
        consumed        = 1'b1;
        steer_goal_next = sat_val;
      end else if (item.frame_id == ids.id_estop) begin
        consumed = 1'b1;
        if (estop_on) begin
          throttle_reg_next = '0;
          brake_reg_next    = 1'b1;
        end else if (estop_off) begin
          throttle_reg_next = CREEP_THROTTLE;
          brake_reg_next    = 1'b0;
        end
      end else if (item.frame_id == ids.id_motor && mode_reg == MODE_MANUAL) begin
        consumed          = 1'b1;
        throttle_reg_next = sat_val;
      end else if (item.frame_id == ids.id_motor && mode_reg == MODE_DEBUG) begin
        consumed          = 1'b1;
        throttle_reg_next = CREEP_THROTTLE;
      end
    end

    if (!consumed && item.time_elapsed) begin
      steer_position_next = smooth_pos;
      ran                 = 1'b1;
    end

    res.steer_out     = steer_position_next;
    res.throttle_goal = throttle_reg_next;
    res.brake_on      = brake_reg_next;
    res.drive_mode    = mode_reg_next;
    res.pid_clear     = pid_clear;
    res.control_ran   = ran;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= MODE_MANUAL;
      steer_goal     <= '0;
      steer_position <= '0;
      throttle_reg   <= '0;
      brake_reg      <= 1'b0;
    end else if (go) begin
      mode_reg       <= mode_reg_next;
      steer_goal     <= steer_goal_next;
      steer_position <= steer_position_next;
      throttle_reg   <= throttle_reg_next;
      brake_reg      <= brake_reg_next;
    end
  end

endmodule

// ----- rtl/drive_command_steering_smoother.sv -----
// An accepted input waits in the input register and moves to the result register,
// which drives m_tvalid, once that register is empty or its result is taken.
// Throughput: one item per cycle while m_tready does not stall the output; the
// state update and steering step are combinational between the two registers.
// Reset (rst, synchronous): mode manual, steering and throttle targets zero,
// brake released, frame identifiers 0..3, both pipeline registers empty.
module drive_command_steering_smoother (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // frame_id[10:0], frame_len[14:11], byte_low[22:15], byte_high[30:23],
  // time_elapsed[31]
  input  logic [31:0]                 s_tdata,
  // operation[0]
  input  logic [0:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // steer_out[14:0], throttle_goal[29:15], brake_on[30], drive_mode[32:31],
  // pid_clear[33], control_ran[34], zero[39:35]
  output logic [39:0]                 m_tdata,
  input  logic                        cfg_we,
  input  logic [dcss_pkg::AddrW-1:0]  cfg_addr,
  input  logic [dcss_pkg::IdW-1:0]    cfg_data
);
  import dcss_pkg::*;

  ids_t    ids;
  item_t   in_item;
  logic    in_valid;
  result_t core_res;
  result_t out_res;
  logic    accept_in;
  logic    advance;

  assign s_tready  = !in_valid || !m_tvalid || m_tready;
  assign accept_in = s_tvalid && s_tready;
  assign advance   = in_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ids.id_mode  <= IdW'(0);
      ids.id_steer <= IdW'(1);
      ids.id_estop <= IdW'(2);
      ids.id_motor <= IdW'(3);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ID_MODE:  ids.id_mode  <= cfg_data;
        REG_ID_STEER: ids.id_steer <= cfg_data;
        REG_ID_ESTOP: ids.id_estop <= cfg_data;
        REG_ID_MOTOR: ids.id_motor <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept_in) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      in_item.operation    <= s_tuser[0];
      in_item.frame_id     <= s_tdata[10:0];
      in_item.frame_len    <= s_tdata[14:11];
      in_item.byte_low     <= s_tdata[22:15];
      in_item.byte_high    <= s_tdata[30:23];
      in_item.time_elapsed <= s_tdata[31];
    end
  end

  dcss_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ids  (ids),
    .go   (advance),
    .item (in_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_tdata = {5'b0, out_res.control_ran, out_res.pid_clear, out_res.drive_mode,
                    out_res.brake_on, out_res.throttle_goal, out_res.steer_out};

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("input register lost an item under stall");

  a_clear_no_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.pid_clear && out_res.control_ran))
    else $error("pid clear and steering step in one result");

  a_steer_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.steer_out <= UNIT_ONE && out_res.steer_out >= -UNIT_ONE))
    else $error("steering position out of range");

  a_throttle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.throttle_goal <= UNIT_ONE && out_res.throttle_goal >= -UNIT_ONE))
    else $error("throttle target out of range");

endmodule

// ----- test/tb_drive_command_steering_smoother.sv -----
module tb_drive_command_steering_smoother;
  timeunit 1ns;
  timeprecision 1ps;

  import dcss_pkg::*;

  localparam int Unit       = int'(dcss_pkg::UNIT_ONE);
  localparam int Creep      = int'(dcss_pkg::CREEP_THROTTLE);
  localparam int RawScale   = int'(dcss_pkg::RAW_SCALE);
  localparam int DeadZone   = int'(dcss_pkg::DEADBAND);
  localparam int CloseZone  = int'(dcss_pkg::CLOSE_BAND);
  localparam int DirectZone = int'(dcss_pkg::DIRECT_TURN);
  localparam int JumpStep   = int'(dcss_pkg::LARGE_STEP);
  localparam int MidZone    = int'(dcss_pkg::MEDIUM_BAND);
  localparam int GainMajor  = 65;
  localparam int GainMinor  = 25;
  localparam int GainDen    = 100;
  localparam int CycleLimit = 200000;
  localparam logic [0:0] OpTick = ~dcss_pkg::OP_FRAME;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [31:0]                 s_tdata = '0;
  logic [0:0]                  s_tuser = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [39:0]                 m_tdata;
  logic                        cfg_we = 1'b0;
  logic [dcss_pkg::AddrW-1:0]  cfg_addr = '0;
  logic [dcss_pkg::IdW-1:0]    cfg_data = '0;

  drive_command_steering_smoother i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predicted block state
  logic [dcss_pkg::IdW-1:0]   id_mode_cfg  = 11'd0;
  logic [dcss_pkg::IdW-1:0]   id_steer_cfg = 11'd1;
  logic [dcss_pkg::IdW-1:0]   id_estop_cfg = 11'd2;
  logic [dcss_pkg::IdW-1:0]   id_motor_cfg = 11'd3;
  logic [dcss_pkg::ModeW-1:0] mode_now     = dcss_pkg::MODE_MANUAL;
  int                         steer_target = 0;
  int                         steer_pos    = 0;
  int                         throttle_now = 0;
  logic                       brake_now    = 1'b0;

  result_t pending_status_q[$];

  int fail_count    = 0;
  int items_sent    = 0;
  int ticks_sent    = 0;
  int results_seen  = 0;
  int settings_used = 0;
  int cycle_count   = 0;
  int send_idle_pct = 33;
  int recv_idle_pct = 33;
  int hold_target   = 0;
  int hold_count    = 0;

  function automatic int clamp_unit(int v);
    if (v > Unit) return Unit;
    if (v < -Unit) return -Unit;
    return v;
  endfunction

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int smooth_toward(int goal, int pos);
    int t;
    int d;
    int ad;
    t = goal;
    if (mag(t) < DeadZone) t = 0;
    d = t - pos;
    ad = mag(d);
    if (ad < CloseZone) return t;
    if (mag(t) > DirectZone || ad > JumpStep) return clamp_unit(t);
    if (mag(t) > MidZone) return clamp_unit(pos + (d * GainMajor) / GainDen);
    return clamp_unit(pos + (d * GainMinor) / GainDen);
  endfunction

  function automatic result_t drive_status_after(item_t it);
    result_t    r;
    logic [15:0] word;
    int         raw;
    int         val;
    bit         consumed;
    consumed = 1'b0;
    r = '0;
    if (it.operation == dcss_pkg::OP_FRAME) begin
      word = {it.byte_high, it.byte_low};
      raw = int'($signed(word));
      val = (it.frame_len < 2) ? int'(it.byte_low) * Unit : clamp_unit(raw * RawScale);
      if (it.frame_id == id_mode_cfg) begin
        consumed = 1'b1;
        if (raw >= 0 && raw <= 2) begin
          mode_now = raw[1:0];
          r.pid_clear = 1'b1;
          steer_pos = steer_target;
          if (raw != 0) begin
            throttle_now = 0;
            steer_target = 0;
          end
        end
      end else if (it.frame_id == id_steer_cfg) begin
        consumed = 1'b1;
        steer_target = clamp_unit(val);
      end else if (it.frame_id == id_estop_cfg) begin
        consumed = 1'b1;
        if (val == Unit || val == 5 * Unit) begin
          throttle_now = 0;
          brake_now = 1'b1;
        end else if (val == 0) begin
          throttle_now = Creep;
          brake_now = 1'b0;
        end
      end else if (it.frame_id == id_motor_cfg && mode_now == dcss_pkg::MODE_MANUAL) begin
        consumed = 1'b1;
        throttle_now = clamp_unit(val);
      end else if (it.frame_id == id_motor_cfg && mode_now == dcss_pkg::MODE_DEBUG) begin
        consumed = 1'b1;
        throttle_now = Creep;
      end
    end
    if (!consumed && it.time_elapsed) begin
      steer_pos = smooth_toward(steer_target, steer_pos);
      r.control_ran = 1'b1;
    end
    r.steer_out = steer_pos[14:0];
    r.throttle_goal = throttle_now[14:0];
    r.brake_on = brake_now;
    r.drive_mode = mode_now;
    return r;
  endfunction

  function automatic item_t mk_frame(input logic [dcss_pkg::IdW-1:0] fid,
                                     input logic [3:0] flen, input logic [15:0] bytes,
                                     input logic te);
    item_t it;
    it.operation = dcss_pkg::OP_FRAME;
    it.frame_id = fid;
    it.frame_len = flen;
    it.byte_low = bytes[7:0];
    it.byte_high = bytes[15:8];
    it.time_elapsed = te;
    return it;
  endfunction

  function automatic item_t mk_tick(input logic te);
    item_t it;
    it.frame_id = 11'($urandom);
    it.frame_len = 4'($urandom);
    it.byte_low = 8'($urandom);
    it.byte_high = 8'($urandom);
    it.operation = OpTick;
    it.time_elapsed = te;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int          pick;
    int          raw;
    logic [15:0] bytes;
    it.operation = ($urandom_range(99) < 20) ? OpTick : dcss_pkg::OP_FRAME;
    if ($urandom_range(9) < 7) begin
      case ($urandom_range(3))
        0: it.frame_id = id_mode_cfg;
        1: it.frame_id = id_steer_cfg;
        2: it.frame_id = id_estop_cfg;
        default: it.frame_id = id_motor_cfg;
      endcase
    end else begin
      it.frame_id = 11'($urandom_range(2047));
    end
    pick = $urandom_range(9);
    if (pick < 4) begin
      raw = int'($urandom_range(240)) - 120;
      bytes = 16'(raw);
      it.frame_len = 4'($urandom_range(8, 2));
    end else if (pick < 6) begin
      bytes = {8'($urandom), 8'($urandom_range(6))};
      it.frame_len = 4'($urandom_range(1));
    end else if (pick < 7) begin
      bytes = 16'($urandom_range(3));
      it.frame_len = 4'($urandom_range(8));
    end else begin
      bytes = 16'($urandom);
      it.frame_len = 4'($urandom_range(8));
    end
    it.byte_low = bytes[7:0];
    it.byte_high = bytes[15:8];
    it.time_elapsed = ($urandom_range(99) < 75);
    return it;
  endfunction

  task automatic send_item(input item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.operation;
    s_tdata <= {it.time_elapsed, it.byte_high, it.byte_low, it.frame_len, it.frame_id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_status_q.push_back(drive_status_after(it));
    items_sent++;
    if (it.operation == OpTick) ticks_sent++;
  endtask

  task automatic quiesce();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_ids(input logic [10:0] m, input logic [10:0] s,
                         input logic [10:0] e, input logic [10:0] mo);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= dcss_pkg::REG_ID_MODE;
    cfg_data <= m;
    @(negedge clk);
    cfg_addr <= dcss_pkg::REG_ID_STEER;
    cfg_data <= s;
    @(negedge clk);
    cfg_addr <= dcss_pkg::REG_ID_ESTOP;
    cfg_data <= e;
    @(negedge clk);
    cfg_addr <= dcss_pkg::REG_ID_MOTOR;
    cfg_data <= mo;
    @(negedge clk);
    cfg_we <= 1'b0;
    id_mode_cfg = m;
    id_steer_cfg = s;
    id_estop_cfg = e;
    id_motor_cfg = mo;
    settings_used++;
  endtask

  task automatic test_reset_values();
    send_item(mk_tick(1'b0));
    send_item(mk_tick(1'b1));
  endtask

  task automatic test_frame_values();
    send_item(mk_frame(id_steer_cfg, 4'd2, 16'h7FFF, 1'b0));
    send_item(mk_tick(1'b1));
    send_item(mk_frame(id_steer_cfg, 4'd8, 16'h8000, 1'b1));
    send_item(mk_frame(id_steer_cfg, 4'd0, 16'h00FF, 1'b0));
    send_item(mk_frame(id_steer_cfg, 4'd1, 16'hFF00, 1'b0));
  endtask

  task automatic test_steering_bands();
    send_item(mk_frame(id_steer_cfg, 4'd2, 16'(8), 1'b0));
    send_item(mk_tick(1'b1));
    send_item(mk_tick(1'b1));
    send_item(mk_frame(id_steer_cfg, 4'd2, 16'(-15), 1'b0));
    send_item(mk_tick(1'b1));
    // goal inside the deadband
    send_item(mk_frame(id_steer_cfg, 4'd3, 16'(2), 1'b0));
    send_item(mk_tick(1'b1));
    send_item(mk_frame(id_steer_cfg, 4'd2, 16'(30), 1'b0));
    send_item(mk_tick(1'b1));
    send_item(mk_frame(id_steer_cfg, 4'd2, 16'(31), 1'b0));
    send_item(mk_tick(1'b1));
  endtask

  task automatic test_commands();
    send_item(mk_frame(id_mode_cfg, 4'd2, 16'(2), 1'b0));
    send_item(mk_frame(id_motor_cfg, 4'd2, 16'(50), 1'b1));
    send_item(mk_frame(id_mode_cfg, 4'd2, 16'(3), 1'b1));
    send_item(mk_frame(id_mode_cfg, 4'd0, 16'(0), 1'b0));
    // motor frame in auto mode falls through to the smoother
    send_item(mk_frame(id_motor_cfg, 4'd2, 16'(-200), 1'b1));
    send_item(mk_frame(id_mode_cfg, 4'd8, 16'(1), 1'b0));
    send_item(mk_frame(id_motor_cfg, 4'd2, 16'(-200), 1'b0));
    send_item(mk_frame(id_estop_cfg, 4'd0, 16'h0001, 1'b0));
    send_item(mk_frame(id_estop_cfg, 4'd2, 16'h0000, 1'b0));
    send_item(mk_frame(id_estop_cfg, 4'd1, 16'hA505, 1'b0));
    send_item(mk_frame(id_estop_cfg, 4'd2, 16'(7), 1'b1));
    send_item(mk_frame(11'h7FF, 4'd4, 16'h1234, 1'b1));
    send_item(mk_frame(11'h7FF, 4'd4, 16'h1234, 1'b0));
  endtask

  task automatic run_phase(input logic [10:0] m, input logic [10:0] s,
                           input logic [10:0] e, input logic [10:0] mo,
                           input int count, input bit no_idle);
    quiesce();
    set_ids(m, s, e, mo);
    send_idle_pct = no_idle ? 0 : 33;
    recv_idle_pct = no_idle ? 0 : 33;
    repeat (count) send_item(random_item());
    send_idle_pct = 33;
    recv_idle_pct = 33;
  endtask

  task automatic test_random_settings();
    run_phase(11'd0, 11'd1, 11'd2, 11'd3, 240, 1'b0);
    run_phase(11'd2047, 11'd2046, 11'd2045, 11'd2044, 240, 1'b0);
    // equal identifiers: mode beats steer beats estop beats motor
    run_phase(11'd9, 11'd9, 11'd9, 11'd9, 240, 1'b0);
    run_phase(11'd4, 11'd8, 11'd8, 11'd8, 240, 1'b1);
    run_phase(11'd4, 11'd5, 11'd6, 11'd6, 240, 1'b0);
    repeat (3) begin
      run_phase(11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom), 240, 1'b0);
    end
  endtask

  task automatic test_output_backpressure();
    hold_target = hold_count + 300;
    send_idle_pct = 0;
    repeat (40) send_item(random_item());
    send_idle_pct = 33;
  endtask

  always @(negedge clk) begin
    if (hold_count < hold_target) begin
      m_tready <= 1'b0;
      hold_count++;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_status_q.size() == 0) begin
        $error("unexpected result transfer %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_status_q.pop_front();
        check_field("steer_out", want.steer_out, $signed(m_tdata[14:0]));
        check_field("throttle_goal", want.throttle_goal, $signed(m_tdata[29:15]));
        check_field("brake_on", want.brake_on, m_tdata[30]);
        check_field("drive_mode", want.drive_mode, m_tdata[32:31]);
        check_field("pid_clear", want.pid_clear, m_tdata[33]);
        check_field("control_ran", want.control_ran, m_tdata[34]);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_status_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_frame_values();
    test_steering_bands();
    test_commands();
    test_random_settings();
    test_output_backpressure();
    quiesce();
    repeat (10) @(posedge clk);
    $display("%0d transfers in (%0d timeout ticks), %0d results checked, %0d errors",
             items_sent, ticks_sent, results_seen, fail_count);
    $display("%0d identifier settings incl. equal ids; one 300-cycle output stall",
             settings_used);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dcss_pkg.sv
rtl/dcss_smooth.sv
rtl/dcss_core.sv
rtl/drive_command_steering_smoother.sv
test/tb_drive_command_steering_smoother.sv
